FILE: rtl/spod_pkg.sv
// Shared types and constants for the sphere pair overlap detector.
// No dependencies.
package spod_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int IDX_W       = 6;   // body index fields
  localparam int CNT_W       = 7;   // body_count register
  localparam int MAX_RESULTS = 63;  // pair cap per scan
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Control of the shared square/accumulate unit
  typedef struct packed {
    logic sq_en;     // register operand squared
    logic acc_load;  // acc <= product
    logic acc_add;   // acc <= acc + product
  } sq_ctrl_t;

endpackage

FILE: rtl/spod_sqacc.sv
// Shared squaring unit with accumulator for the overlap detector.
// Depends on spod_pkg (sq_ctrl_t).
module spod_sqacc #(
  parameter int OW = spod_pkg::COORD_BITS_DEF + 1
) (
  input  logic              clk,
  input  spod_pkg::sq_ctrl_t ctrl,
  input  logic [OW-1:0]     operand,
  output logic [2*OW-1:0]   sq_prod,
  output logic [2*OW-1:0]   sq_acc
);

  logic [2*OW-1:0] prod_r;
  logic [2*OW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.sq_en) begin
      prod_r <= (2*OW)'(operand) * (2*OW)'(operand);
    end
    if (ctrl.acc_load) begin
      acc_r <= prod_r;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + prod_r;   // three squares fit in 2*OW bits
    end
  end

  assign sq_prod = prod_r;
  assign sq_acc  = acc_r;

endmodule

FILE: rtl/sphere_pair_overlap_detector.sv
// Sphere pair overlap detector: sphere store, scan sequencer, output register.
// Depends on spod_pkg and spod_sqacc.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | kind, body_index, centre x/y/z, radius
//   out_    | output    | out_valid/out_stall | hit, first_index, second_index, last
//   cfg_    | input     | cfg_wr_en           | cfg_wr_data = body_count
//
// A load request is written to the store while the sequencer stays idle. A scan
// of body i steps through each body j above it: diff, four passes through the
// one squarer, compare; the shared squarer sets the length of a scan.
// in_stall is high from scan acceptance until the final result is registered.
// out_stall holds the sequencer only when a result has to move out.
// Synchronous active-low reset clears control state; the store is not cleared.
module sphere_pair_overlap_detector #(
  parameter int MAX_BODIES = spod_pkg::MAX_BODIES_DEF,
  parameter int COORD_BITS = spod_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        cfg_wr_en,
  input  logic [spod_pkg::CNT_W-1:0]  cfg_wr_data,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [spod_pkg::IDX_W-1:0]  in_body_index,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic signed [COORD_BITS-1:0] in_center_z,
  input  logic [COORD_BITS-1:0]       in_sphere_radius,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [spod_pkg::IDX_W-1:0]  out_first_index,
  output logic [spod_pkg::IDX_W-1:0]  out_second_index,
  output logic                        out_last
);

  localparam int AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CB    = COORD_BITS;
  localparam int OW    = CB + 1;          // radius sum needs one extra bit
  localparam int PW    = 2 * OW;
  localparam int EW    = 4 * CB;          // {x, y, z, r}
  localparam int CNT_W = spod_pkg::CNT_W;
  localparam int IDX_W = spod_pkg::IDX_W;
  localparam int RES_W = spod_pkg::RES_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOADI = 6'b000010,
    S_DIFF  = 6'b000100,
    S_SQ    = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] cfg_body_count_r;
  logic [CNT_W-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_body_count_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_body_count_r <= cfg_wr_data;
    end
  end

  // Counts above the store depth act as the depth
  assign n_eff = (int'(cfg_body_count_r) > MAX_BODIES) ? CNT_W'(MAX_BODIES)
                                                       : cfg_body_count_r;

  // ---------------------------------------------------------------------
  // Sphere store: one write port (loads), one registered read port
  // ---------------------------------------------------------------------
  logic [EW-1:0] store_mem [MAX_BODIES];
  logic [EW-1:0] rd_q_r;
  logic [AW-1:0] rd_addr;
  logic          in_acc;
  logic          ld_en;

  assign in_acc = in_valid && !in_stall;
  assign ld_en  = in_acc && (in_kind == spod_pkg::KIND_LOAD) &&
                  (int'(in_body_index) < MAX_BODIES);

  always_ff @(posedge clk) begin
    if (ld_en) begin
      store_mem[AW'(in_body_index)] <= {in_center_x, in_center_y, in_center_z,
                                        in_sphere_radius};
    end
    rd_q_r <= store_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Scan registers
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]     i_r;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [RES_W-1:0]     count_r, count_nxt;
  logic [1:0]           step_r, step_nxt;
  logic signed [CB-1:0] xi_r, yi_r, zi_r;
  logic [CB-1:0]        ri_r;
  logic [OW-1:0]        dx_r, dy_r, dz_r, rs_r;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]     pend_j_r, pend_j_nxt;

  // body j fields straight from the read register
  logic signed [CB-1:0] xj, yj, zj;
  logic [CB-1:0]        rj;
  assign {xj, yj, zj, rj} = rd_q_r;

  logic [CNT_W:0] j_inc;
  assign j_inc = {1'b0, j_r} + (CNT_W+1)'(1);

  // |a - b| in OW bits
  function automatic logic [OW-1:0] abs_diff(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [OW-1:0] d;
    d = OW'(a) - OW'(b);
    abs_diff = d[OW-1] ? OW'(-d) : OW'(d);
  endfunction

  // ---------------------------------------------------------------------
  // Shared square / accumulate unit
  // ---------------------------------------------------------------------
  spod_pkg::sq_ctrl_t sq_ctrl;
  logic [OW-1:0]      sq_operand;
  logic [PW-1:0]      sq_prod, sq_acc;
  logic               pair_hit;

  always_comb begin
    case (step_r)
      2'd0:    sq_operand = dx_r;
      2'd1:    sq_operand = dy_r;
      2'd2:    sq_operand = dz_r;
      default: sq_operand = rs_r;
    endcase
    sq_ctrl.sq_en    = (state_r == S_SQ);
    sq_ctrl.acc_load = (state_r == S_SQ) && (step_r == 2'd1);
    sq_ctrl.acc_add  = (state_r == S_SQ) && (step_r != 2'd0) && (step_r != 2'd1);
  end

  spod_sqacc #(.OW(OW)) u_sqacc (
    .clk     (clk),
    .ctrl    (sq_ctrl),
    .operand (sq_operand),
    .sq_prod (sq_prod),
    .sq_acc  (sq_acc)
  );

  // at compare time: acc = dx^2+dy^2+dz^2, prod = (ri+rj)^2; touching is no hit
  assign pair_hit = (sq_acc < sq_prod);

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic             out_valid_r;
  logic             out_hit_r, out_last_r;
  logic [IDX_W-1:0] out_first_r, out_second_r;
  logic             out_free;
  logic             out_load;
  logic             out_hit_nxt, out_last_nxt;
  logic [IDX_W-1:0] out_second_nxt;

  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    j_nxt          = j_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    pend_valid_nxt = pend_valid_r;
    pend_j_nxt     = pend_j_r;
    out_load       = 1'b0;
    out_hit_nxt    = 1'b0;
    out_last_nxt   = 1'b0;
    out_second_nxt = '0;
    rd_addr        = AW'(j_r);

    unique case (state_r)
      S_IDLE: begin
        rd_addr = AW'(in_body_index);
        if (in_acc && (in_kind == spod_pkg::KIND_SCAN)) begin
          count_nxt      = '0;
          pend_valid_nxt = 1'b0;
          j_nxt          = CNT_W'(in_body_index) + CNT_W'(1);
          if (CNT_W'(in_body_index) < n_eff) begin
            state_nxt = S_LOADI;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_LOADI: begin
        // body i arrives now; body j read is issued
        rd_addr = AW'(j_r);
        if (j_r < n_eff) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DIFF: begin
        step_nxt  = 2'd0;
        state_nxt = S_SQ;
      end

      S_SQ: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        rd_addr = AW'(j_inc);
        if (!(pair_hit && pend_valid_r && !out_free)) begin
          if (pair_hit) begin
            if (pend_valid_r) begin
              out_load       = 1'b1;
              out_hit_nxt    = 1'b1;
              out_second_nxt = pend_j_r;
            end
            pend_valid_nxt = 1'b1;
            pend_j_nxt     = IDX_W'(j_r);
            count_nxt      = count_r + RES_W'(1);
          end
          j_nxt = CNT_W'(j_inc);
          if ((pair_hit && (int'(count_r) == spod_pkg::MAX_RESULTS - 1)) ||
              (j_inc >= {1'b0, n_eff})) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_hit_nxt    = pend_valid_r;
          out_second_nxt = pend_valid_r ? pend_j_r : '0;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      count_r      <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    step_r   <= step_nxt;
    pend_j_r <= pend_j_nxt;
    if (state_r == S_IDLE && in_acc) begin
      i_r <= in_body_index;
    end
    if (state_r == S_LOADI) begin
      {xi_r, yi_r, zi_r, ri_r} <= rd_q_r;
    end
    if (state_r == S_DIFF) begin
      dx_r <= abs_diff(xi_r, xj);
      dy_r <= abs_diff(yi_r, yj);
      dz_r <= abs_diff(zi_r, zj);
      rs_r <= OW'(ri_r) + OW'(rj);
    end
    if (out_load) begin
      out_hit_r    <= out_hit_nxt;
      out_first_r  <= i_r;
      out_second_r <= out_second_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_first_index  = out_first_r;
  assign out_second_index = out_second_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  // an empty scan result always closes the scan
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last)
    else $error("empty result without last");

  // no pair is left pending once the sequencer is back in idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending pair in idle");

  // compared body always lies above the scanned body
  a_j_above_i: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIFF |-> j_r > CNT_W'(i_r))
    else $error("compare index not above scanned body");

  // pair cap is never exceeded
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= spod_pkg::MAX_RESULTS)
    else $error("pair count beyond cap");

  // a result moved out mid-scan never carries last
  a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && state_r == S_CMP |=> out_valid && !out_last && out_hit)
    else $error("mid-scan result flagged last");
`endif

endmodule

FILE: dv/sphere_pair_overlap_detector_test.sv
// Self-checking bench for sphere_pair_overlap_detector: directed table, then random phases.
// Depends on spod_pkg and the RTL of the detector. It carries its own pair predictor.
module sphere_pair_overlap_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBODY        = spod_pkg::MAX_BODIES_DEF;
  localparam int COORD_W      = spod_pkg::COORD_BITS_DEF;
  localparam int IDX_W        = spod_pkg::IDX_W;
  localparam int CNT_W        = spod_pkg::CNT_W;
  localparam int PHASE_ITEMS  = 40;     // random requests per body_count setting
  localparam int QUIET_FROM   = 180;    // no idling on either side in this request window
  localparam int QUIET_TO     = 280;
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the block
  localparam int IDLE_SETTLE  = 32;     // cycles after the last result before a cfg write
  localparam int END_SETTLE   = 400;    // cycles after the last result before the end of the run

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   body;
    coord_t             cx;
    coord_t             cy;
    coord_t             cz;
    logic [COORD_W-1:0] rad;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;
    logic             is_last;
  } result_t;

  typedef struct {
    int       count;   // body_count in force for this row
    request_t req;
    bit       typed;   // expectation written into the table
    result_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic in_valid, in_stall, in_kind;
  logic [IDX_W-1:0] in_body_index;
  coord_t in_center_x, in_center_y, in_center_z;
  logic [COORD_W-1:0] in_sphere_radius;
  logic out_valid, out_hit, out_last;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_first_index, out_second_index;

  // Bench copy of the block's state and register
  request_t stored_spheres[NBODY];
  bit       loaded[NBODY];
  int       active_bodies = 0;

  result_t pending_pairs[$];   // expected results, oldest first
  int      mismatches = 0;
  int      pairs_seen = 0;
  int      n_sent = 0;
  logic    quiet = 1'b0;      // suppresses random idling on both sides
  logic    hold_off = 1'b0;
  int      cluster_x, cluster_y, cluster_z;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sphere_pair_overlap_detector i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_body_index    (in_body_index),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_center_z      (in_center_z),
    .in_sphere_radius (in_sphere_radius),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_last         (out_last)
  );

  // ---------------------------------------------------------------- predictor
  // Strict compare: touching spheres (equal squares) are no overlap.
  // 64-bit signed holds every square sum at 16-bit coordinates exactly.
  function automatic bit spheres_overlap(request_t a, request_t b);
    longint dx, dy, dz, rsum;
    dx   = longint'(a.cx) - longint'(b.cx);
    dy   = longint'(a.cy) - longint'(b.cy);
    dz   = longint'(a.cz) - longint'(b.cz);
    rsum = longint'(a.rad) + longint'(b.rad);
    return (dx * dx + dy * dy + dz * dz) < (rsum * rsum);
  endfunction

  // Pairs of one scan, ascending j. A count above the store acts as the store size;
  // a body at or beyond the count, or no overlap at all, gives one empty result.
  function automatic void predict_pairs(logic [IDX_W-1:0] body);
    int n;
    int found;
    result_t res;
    n = (active_bodies > NBODY) ? NBODY : active_bodies;
    found = 0;
    if (int'(body) < n) begin
      for (int j = int'(body) + 1; j < n && found < spod_pkg::MAX_RESULTS; j++) begin
        if (spheres_overlap(stored_spheres[body], stored_spheres[j])) begin
          res = '{1'b1, body, IDX_W'(j), 1'b0};
          pending_pairs.push_back(res);
          found++;
        end
      end
    end
    if (found == 0) begin
      res = '{1'b0, body, '0, 1'b1};
      pending_pairs.push_back(res);
    end else begin
      pending_pairs[pending_pairs.size() - 1].is_last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic row_t load_row(int count, int slot, int x, int y, int z, int r);
    row_t row;
    row.count    = count;
    row.req.kind = spod_pkg::KIND_LOAD;
    row.req.body = IDX_W'(slot);
    row.req.cx   = coord_t'(x);
    row.req.cy   = coord_t'(y);
    row.req.cz   = coord_t'(z);
    row.req.rad  = COORD_W'(r);
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  // Typed scan rows are all single-result scans, so last is always set.
  function automatic row_t scan_row(int count, int body, bit typed = 1'b0,
                                    bit hit = 1'b0, int pair = 0);
    row_t row;
    row.count    = count;
    row.req      = '0;
    row.req.kind = spod_pkg::KIND_SCAN;
    row.req.body = IDX_W'(body);
    row.typed    = typed;
    row.want     = '{hit, IDX_W'(body), IDX_W'(pair), 1'b1};
    return row;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly spheres clustered round the phase centre so that overlaps are common,
  // plus some fully random and some extreme ones for bit and range coverage.
  function automatic request_t make_load(int slot);
    request_t rq;
    int mode;
    rq.kind = spod_pkg::KIND_LOAD;
    rq.body = IDX_W'(slot);
    mode = $urandom_range(9);
    if (mode == 0) begin
      rq.cx  = coord_t'($urandom);
      rq.cy  = coord_t'($urandom);
      rq.cz  = coord_t'($urandom);
      rq.rad = COORD_W'($urandom);
    end else if (mode == 1) begin
      rq.cx  = coord_t'(extreme_coord());
      rq.cy  = coord_t'(extreme_coord());
      rq.cz  = coord_t'(extreme_coord());
      rq.rad = $urandom_range(1) ? '1 : COORD_W'($urandom_range(1));
    end else begin
      rq.cx  = coord_t'(cluster_x + int'($urandom_range(2047)) - 1024);
      rq.cy  = coord_t'(cluster_y + int'($urandom_range(2047)) - 1024);
      rq.cz  = coord_t'(cluster_z + int'($urandom_range(2047)) - 1024);
      rq.rad = COORD_W'($urandom_range(1023));
    end
    return rq;
  endfunction

  // Offer one request and hold it until taken; prediction happens at the
  // accepting edge, so expectations always queue in request order.
  task automatic send_request(request_t rq, bit typed = 1'b0, result_t want = '0);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= rq.kind;
    in_body_index    <= rq.body;
    in_center_x      <= rq.cx;
    in_center_y      <= rq.cy;
    in_center_z      <= rq.cz;
    in_sphere_radius <= rq.rad;
    do @(posedge clk); while (in_stall);
    n_sent++;
    quiet <= (n_sent >= QUIET_FROM && n_sent < QUIET_TO);
    if (rq.kind == spod_pkg::KIND_LOAD) begin
      stored_spheres[rq.body] = rq;
      loaded[rq.body] = 1'b1;
    end else if (typed) begin
      pending_pairs.push_back(want);
    end else begin
      predict_pairs(rq.body);
    end
  endtask

  // Drop valid, let every expected result arrive, then let the block settle.
  task automatic wait_drained(int settle);
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_body_count(int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_bodies = value & ((1 << CNT_W) - 1);
  endtask

  task automatic note_mismatch(string field, int want, int got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------- result side
  // Checks each accepted result against the oldest expectation and drives
  // out_stall: random stalls, none in the quiet window, solid during hold_off.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        note_mismatch("unexpected result, first_index", -1, out_first_index);
      end else begin
        want = pending_pairs.pop_front();
        if (out_hit !== want.hit)
          note_mismatch("hit", want.hit, out_hit);
        if (out_first_index !== want.first_idx)
          note_mismatch("first_index", want.first_idx, out_first_index);
        if (out_second_index !== want.second_idx)
          note_mismatch("second_index", want.second_idx, out_second_index);
        if (out_last !== want.is_last)
          note_mismatch("last", want.is_last, out_last);
      end
    end
    out_stall <= hold_off || (!quiet && $urandom_range(99) < 15);
  end

  // Long hold-off once traffic is flowing: the block backs up into in_stall
  // while the sender keeps offering.
  initial begin
    wait (pairs_seen >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: well above the slowest correct run.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    row_t     directed[$];
    int       phase_counts[$];
    int       eff;
    request_t rq;

    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_kind          <= spod_pkg::KIND_LOAD;
    in_body_index    <= '0;
    in_center_x      <= '0;
    in_center_y      <= '0;
    in_center_z      <= '0;
    in_sphere_radius <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset body_count is 0: every scan is out of range
    directed.push_back(scan_row(0, 0, 1'b1));
    directed.push_back(scan_row(0, 63, 1'b1));
    // Coincident centres, both radii zero: equal squares, so no overlap
    directed.push_back(load_row(2, 0, 100, 100, 100, 0));
    directed.push_back(load_row(2, 1, 100, 100, 100, 0));
    directed.push_back(scan_row(2, 0, 1'b1));
    directed.push_back(load_row(2, 1, 100, 100, 100, 1));
    directed.push_back(scan_row(2, 0, 1'b1, 1'b1, 1));
    directed.push_back(scan_row(2, 1, 1'b1));          // last body, nothing above it
    directed.push_back(scan_row(1, 0, 1'b1));
    // Touching pair (0,1), coordinate and radius extremes
    directed.push_back(load_row(4, 0, 0, 0, 0, 256));
    directed.push_back(load_row(4, 1, 256, 0, 0, 0));
    directed.push_back(load_row(4, 2, -32768, -32768, -32768, 0));
    directed.push_back(load_row(4, 3, 32767, 32767, 32767, 65535));
    directed.push_back(scan_row(4, 0));
    directed.push_back(scan_row(4, 1));
    directed.push_back(scan_row(4, 2));
    directed.push_back(scan_row(4, 3, 1'b1));
    directed.push_back(scan_row(4, 4, 1'b1));
    directed.push_back(load_row(4, 63, 32767, -32768, 0, 65535));  // slot beyond the count
    directed.push_back(load_row(4, 4, 'hAAAA, 'h5555, 'hAAAA, 'hAAAA));
    directed.push_back(scan_row(5, 0));
    directed.push_back(scan_row(5, 4, 1'b1));

    foreach (directed[k]) begin
      if (directed[k].count != active_bodies) begin
        wait_drained(IDLE_SETTLE);
        set_body_count(directed[k].count);
      end
      send_request(directed[k].req, directed[k].typed, directed[k].want);
    end

    // Random phases; 127 is the register maximum and acts as a full store
    phase_counts = '{64, 3, 127, 16, 0, 40, 1, 64};
    phase_counts.push_back($urandom_range(127));
    foreach (phase_counts[p]) begin
      wait_drained(IDLE_SETTLE);
      set_body_count(phase_counts[p]);
      eff = (phase_counts[p] > NBODY) ? NBODY : phase_counts[p];
      cluster_x = int'($urandom_range(60000)) - 30000;
      cluster_y = int'($urandom_range(60000)) - 30000;
      cluster_z = int'($urandom_range(60000)) - 30000;
      // every slot a scan may read is loaded first
      for (int s = 0; s < eff; s++)
        if (!loaded[s]) send_request(make_load(s));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 55) begin
          rq = '0;
          rq.kind = spod_pkg::KIND_SCAN;
          if (eff > 0 && $urandom_range(9) != 0)
            rq.body = IDX_W'($urandom_range(eff - 1));
          else
            rq.body = IDX_W'($urandom_range(NBODY - 1));
          send_request(rq);
        end else begin
          send_request(make_load($urandom_range(NBODY - 1)));
        end
      end
    end

    wait_drained(END_SETTLE);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
